>>> hw/rtl/jls_pkg.sv
// jls_pkg: shared types, character codes and keyword table for the Jack lexer.
// No dependencies; used by jack_lexer_stream_top.sv and tb_top.sv.
package jls_pkg;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_WORD   = 3'd1,
        MODE_STRING = 3'd2,
        MODE_SLASH  = 3'd3,
        MODE_LINE   = 3'd4,
        MODE_BLOCK  = 3'd5,
        MODE_STAR   = 3'd6
    } lex_mode_t;

    // Token classes
    localparam logic [2:0] CLS_KEYWORD = 3'd0;
    localparam logic [2:0] CLS_SYMBOL  = 3'd1;
    localparam logic [2:0] CLS_INTEGER = 3'd2;
    localparam logic [2:0] CLS_STRING  = 3'd3;
    localparam logic [2:0] CLS_IDENT   = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_INT_SAT      = 2'd1;
    localparam logic [1:0] ERR_UNTERM_STR   = 2'd2;
    localparam logic [1:0] ERR_OPEN_COMMENT = 2'd3;

    // Result kinds
    localparam logic EV_CHAR      = 1'b0;
    localparam logic EV_TOKEN_END = 1'b1;

    // Character codes
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [3:0]  WORD_LEN_MAX = 4'd15;
    localparam logic [14:0] INT_MAX      = 15'h7FFF;

    // Keyword dictionary, left-justified and space padded to 11 characters
    localparam int NUM_KEYWORDS = 21;
    localparam int KW_TEXT_LEN  = 11;
    typedef logic [KW_TEXT_LEN-1:0][7:0] kw_text_t;

    localparam kw_text_t KW_TEXT [NUM_KEYWORDS] = '{
        "class      ", "method     ", "function   ", "constructor",
        "int        ", "boolean    ", "char       ", "void       ",
        "var        ", "static     ", "field      ", "let        ",
        "do         ", "if         ", "else       ", "while      ",
        "return     ", "true       ", "false      ", "null       ",
        "this       "
    };

    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd5, 4'd6, 4'd8, 4'd11, 4'd3, 4'd7, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5,
        4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd4, 4'd4
    };

    // One result item
    typedef struct packed {
        logic        event_res;
        logic [7:0]  text_char;
        logic [2:0]  token_class;
        logic [4:0]  keyword_code;
        logic [14:0] int_value;
        logic [1:0]  error;
        logic        last;
    } lex_res_t;

    function automatic lex_res_t mk_res(
        input logic        ev,
        input logic [7:0]  tc,
        input logic [2:0]  cls,
        input logic [4:0]  kw,
        input logic [14:0] iv,
        input logic [1:0]  err
    );
        lex_res_t r;
        r.event_res    = ev;
        r.text_char    = tc;
        r.token_class  = cls;
        r.keyword_code = kw;
        r.int_value    = iv;
        r.error        = err;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        logic s;
        unique case (c)
            "(", ")", "{", "}", "[", "]", ".", ",", ";", "+", "-", "*", "/",
            "&", "<", ">", "=", "|", "~": s = 1'b1;
            default:                      s = 1'b0;
        endcase
        return s;
    endfunction

endpackage

>>> hw/rtl/jls_if.sv
// jls_if: valid/ready channels for source bytes and lexer results.
// No dependencies; none of the jls_pkg types are used.
interface jls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_file;

    modport source (output valid, ch, end_of_file, input ready);
    modport sink   (input valid, ch, end_of_file, output ready);
endinterface

interface jls_out_if;
    logic        valid;
    logic        ready;
    logic        event_res;
    logic [7:0]  text_char;
    logic [2:0]  token_class;
    logic [4:0]  keyword_code;
    logic [14:0] int_value;
    logic [1:0]  error;
    logic        last;

    modport source (output valid, event_res, text_char, token_class, keyword_code,
                    int_value, error, last, input ready);
    modport sink   (input valid, event_res, text_char, token_class, keyword_code,
                    int_value, error, last, output ready);
endinterface

>>> hw/rtl/jack_lexer_stream_top.sv
// Jack lexer: one source byte per request in, zero to two results out per byte.
// An accepted byte waits in the input register until the queue has room for its
// results. Throughput: one byte per cycle while each byte gives at most one result
// and the output is ready; the four-entry result queue drains one result per cycle
// while ready, and takes a byte only while two entries are free. Async active-low
// reset empties the queue and returns the lexer to normal mode with no token open.
// Depends on jls_pkg and jls_if.
module jack_lexer_stream_top #(
    parameter int KEYWORD_MAX_LEN = 11
) (
    input  logic      clk,
    input  logic      rst_n,
    jls_in_if.sink    src,
    jls_out_if.source res
);

    localparam int BUF_AW    = $clog2(KEYWORD_MAX_LEN);
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    // Input register
    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       eof_reg;
    logic       advance;

    // Lexer state
    jls_pkg::lex_mode_t mode_reg, mode_next;
    logic [3:0]  wlen_reg, wlen_next;
    logic        sd_reg, sd_next;
    logic [14:0] acc_reg, acc_next;
    logic        sat_reg, sat_next;
    logic [7:0]  word_buf [KEYWORD_MAX_LEN];

    // Result queue
    jls_pkg::lex_res_t q_mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic            pop;

    // Handshake
    assign advance   = in_valid_reg && (count_reg <= Q_CW'(Q_DEPTH - 2));
    assign src.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (src.ready)
        begin
            in_valid_reg <= src.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            ch_reg  <= src.ch;
            eof_reg <= src.end_of_file;
        end
    end

    // Byte classification
    logic c_space, c_digit, c_symbol, c_quote, c_slash, c_star, c_lf, c_word;
    assign c_space  = jls_pkg::is_space(ch_reg);
    assign c_digit  = jls_pkg::is_digit(ch_reg);
    assign c_symbol = jls_pkg::is_symbol(ch_reg);
    assign c_quote  = (ch_reg == jls_pkg::CH_QUOTE);
    assign c_slash  = (ch_reg == jls_pkg::CH_SLASH);
    assign c_star   = (ch_reg == jls_pkg::CH_STAR);
    assign c_lf     = (ch_reg == jls_pkg::CH_LF);
    assign c_word   = !c_space && !c_symbol && !c_quote;

    // Keyword match against the buffered word
    logic [jls_pkg::NUM_KEYWORDS-1:0] kw_match;
    logic       kw_hit;
    logic [4:0] kw_code;

    always_comb
    begin
        kw_hit  = 1'b0;
        kw_code = '0;
        for (int k = 0; k < jls_pkg::NUM_KEYWORDS; k++)
        begin
            kw_match[k] = (wlen_reg == jls_pkg::KW_LEN[k]);
            for (int i = 0; i < jls_pkg::KW_TEXT_LEN; i++)
            begin
                if ((4'(i) < jls_pkg::KW_LEN[k]) &&
                    (word_buf[i] != jls_pkg::KW_TEXT[k][jls_pkg::KW_TEXT_LEN-1-i]))
                begin
                    kw_match[k] = 1'b0;
                end
            end
        end
        for (int k = 0; k < jls_pkg::NUM_KEYWORDS; k++)
        begin
            if (kw_match[k] && !kw_hit)
            begin
                kw_hit  = 1'b1;
                kw_code = 5'(k);
            end
        end
    end

    // Token-end result for the open word
    jls_pkg::lex_res_t word_end_res;
    always_comb
    begin
        if (sd_reg)
        begin
            word_end_res = jls_pkg::mk_res(jls_pkg::EV_TOKEN_END, 8'h00,
                jls_pkg::CLS_INTEGER, 5'd0, acc_reg,
                sat_reg ? jls_pkg::ERR_INT_SAT : jls_pkg::ERR_NONE);
        end
        else if (kw_hit)
        begin
            word_end_res = jls_pkg::mk_res(jls_pkg::EV_TOKEN_END, 8'h00,
                jls_pkg::CLS_KEYWORD, kw_code, 15'd0, jls_pkg::ERR_NONE);
        end
        else
        begin
            word_end_res = jls_pkg::mk_res(jls_pkg::EV_TOKEN_END, 8'h00,
                jls_pkg::CLS_IDENT, 5'd0, 15'd0, jls_pkg::ERR_NONE);
        end
    end

    // Fixed result shapes
    jls_pkg::lex_res_t char_res, sym_res, slash_res;
    assign char_res  = jls_pkg::mk_res(jls_pkg::EV_CHAR, ch_reg, jls_pkg::CLS_KEYWORD,
                                       5'd0, 15'd0, jls_pkg::ERR_NONE);
    assign sym_res   = jls_pkg::mk_res(jls_pkg::EV_TOKEN_END, ch_reg, jls_pkg::CLS_SYMBOL,
                                       5'd0, 15'd0, jls_pkg::ERR_NONE);
    assign slash_res = jls_pkg::mk_res(jls_pkg::EV_TOKEN_END, jls_pkg::CH_SLASH,
                                       jls_pkg::CLS_SYMBOL, 5'd0, 15'd0, jls_pkg::ERR_NONE);

    // Normal-mode handling of the current byte (also after a word or '/' closes)
    jls_pkg::lex_mode_t nb_mode;
    logic nb_sym, nb_start;
    always_comb
    begin
        nb_sym   = 1'b0;
        nb_start = 1'b0;
        priority if (c_space)
        begin
            nb_mode = jls_pkg::MODE_NORMAL;
        end
        else if (c_quote)
        begin
            nb_mode = jls_pkg::MODE_STRING;
        end
        else if (c_slash)
        begin
            nb_mode = jls_pkg::MODE_SLASH;
        end
        else if (c_symbol)
        begin
            nb_mode = jls_pkg::MODE_NORMAL;
            nb_sym  = 1'b1;
        end
        else
        begin
            nb_mode  = jls_pkg::MODE_WORD;
            nb_start = 1'b1;
        end
    end

    // Next mode
    always_comb
    begin
        unique case (mode_reg)
            jls_pkg::MODE_WORD:
            begin
                if (eof_reg)
                    mode_next = jls_pkg::MODE_NORMAL;
                else if (c_word)
                    mode_next = jls_pkg::MODE_WORD;
                else
                    mode_next = nb_mode;
            end
            jls_pkg::MODE_STRING:
            begin
                if (eof_reg || c_lf || c_quote)
                    mode_next = jls_pkg::MODE_NORMAL;
                else
                    mode_next = jls_pkg::MODE_STRING;
            end
            jls_pkg::MODE_SLASH:
            begin
                if (eof_reg)
                    mode_next = jls_pkg::MODE_NORMAL;
                else if (c_slash)
                    mode_next = jls_pkg::MODE_LINE;
                else if (c_star)
                    mode_next = jls_pkg::MODE_BLOCK;
                else
                    mode_next = nb_mode;
            end
            jls_pkg::MODE_LINE:
            begin
                if (eof_reg || c_lf)
                    mode_next = jls_pkg::MODE_NORMAL;
                else
                    mode_next = jls_pkg::MODE_LINE;
            end
            jls_pkg::MODE_BLOCK, jls_pkg::MODE_STAR:
            begin
                if (eof_reg)
                    mode_next = jls_pkg::MODE_NORMAL;
                else if (c_star)
                    mode_next = jls_pkg::MODE_STAR;
                else if (mode_reg == jls_pkg::MODE_STAR && c_slash)
                    mode_next = jls_pkg::MODE_NORMAL;
                else
                    mode_next = jls_pkg::MODE_BLOCK;
            end
            default:
            begin
                mode_next = eof_reg ? jls_pkg::MODE_NORMAL : nb_mode;
            end
        endcase
    end

    // Results and word datapath controls
    logic pre_valid, main_valid;
    jls_pkg::lex_res_t pre_res, main_res;
    logic do_add, do_fresh, do_clear;

    always_comb
    begin
        pre_valid  = 1'b0;
        pre_res    = word_end_res;
        main_valid = 1'b0;
        main_res   = char_res;
        do_add     = 1'b0;
        do_fresh   = 1'b0;
        do_clear   = 1'b0;
        unique case (mode_reg)
            jls_pkg::MODE_WORD:
            begin
                if (eof_reg)
                begin
                    pre_valid = 1'b1;
                    do_clear  = 1'b1;
                end
                else if (c_word)
                begin
                    do_add     = 1'b1;
                    main_valid = 1'b1;
                    if (sd_reg && !c_digit)
                    begin
                        pre_valid = 1'b1;
                        do_fresh  = 1'b1;
                    end
                end
                else
                begin
                    pre_valid  = 1'b1;
                    do_clear   = 1'b1;
                    main_valid = nb_sym;
                    main_res   = sym_res;
                end
            end
            jls_pkg::MODE_STRING:
            begin
                if (eof_reg || c_lf)
                begin
                    pre_valid = 1'b1;
                    pre_res   = jls_pkg::mk_res(jls_pkg::EV_TOKEN_END, 8'h00,
                        jls_pkg::CLS_STRING, 5'd0, 15'd0, jls_pkg::ERR_UNTERM_STR);
                end
                else if (c_quote)
                begin
                    pre_valid = 1'b1;
                    pre_res   = jls_pkg::mk_res(jls_pkg::EV_TOKEN_END, 8'h00,
                        jls_pkg::CLS_STRING, 5'd0, 15'd0, jls_pkg::ERR_NONE);
                end
                else
                begin
                    main_valid = 1'b1;
                end
            end
            jls_pkg::MODE_SLASH:
            begin
                pre_res = slash_res;
                if (eof_reg)
                begin
                    pre_valid = 1'b1;
                end
                else if (!c_slash && !c_star)
                begin
                    pre_valid  = 1'b1;
                    main_valid = nb_sym || nb_start;
                    main_res   = nb_sym ? sym_res : char_res;
                    do_add     = nb_start;
                    do_fresh   = nb_start;
                end
            end
            jls_pkg::MODE_LINE:
            begin
                pre_valid = 1'b0;
            end
            jls_pkg::MODE_BLOCK, jls_pkg::MODE_STAR:
            begin
                pre_res = jls_pkg::mk_res(jls_pkg::EV_TOKEN_END, 8'h00,
                    jls_pkg::CLS_KEYWORD, 5'd0, 15'd0, jls_pkg::ERR_OPEN_COMMENT);
                pre_valid = eof_reg;
            end
            default:
            begin
                if (!eof_reg)
                begin
                    main_valid = nb_sym || nb_start;
                    main_res   = nb_sym ? sym_res : char_res;
                    do_add     = nb_start;
                    do_fresh   = nb_start;
                end
            end
        endcase
    end

    // Word accumulation: length, digit-led flag, saturating integer value
    logic [3:0]  len_base;
    logic        sd_base;
    logic [14:0] acc_base;
    logic        sat_base;
    logic [18:0] acc_prod;
    logic        buf_we;

    assign len_base = do_fresh ? 4'd0  : wlen_reg;
    assign sd_base  = do_fresh ? c_digit : sd_reg;
    assign acc_base = do_fresh ? 15'd0 : acc_reg;
    assign sat_base = do_fresh ? 1'b0  : sat_reg;
    assign acc_prod = 19'(acc_base) * 19'd10 + 19'(4'(ch_reg - jls_pkg::CH_ZERO));
    assign buf_we   = advance && do_add && (32'(len_base) < KEYWORD_MAX_LEN);

    always_comb
    begin
        wlen_next = wlen_reg;
        sd_next   = sd_reg;
        acc_next  = acc_reg;
        sat_next  = sat_reg;
        if (do_add)
        begin
            wlen_next = (len_base == jls_pkg::WORD_LEN_MAX) ? len_base : len_base + 4'd1;
            sd_next   = sd_base;
            acc_next  = acc_base;
            sat_next  = sat_base;
            if (sd_base)
            begin
                if (acc_prod > 19'(jls_pkg::INT_MAX))
                begin
                    acc_next = jls_pkg::INT_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_prod[14:0];
                end
            end
        end
        else if (do_clear)
        begin
            wlen_next = 4'd0;
            sd_next   = 1'b0;
            acc_next  = 15'd0;
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= jls_pkg::MODE_NORMAL;
            wlen_reg <= 4'd0;
            sd_reg   <= 1'b0;
            acc_reg  <= 15'd0;
            sat_reg  <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            wlen_reg <= wlen_next;
            sd_reg   <= sd_next;
            acc_reg  <= acc_next;
            sat_reg  <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            word_buf[len_base[BUF_AW-1:0]] <= ch_reg;
        end
    end

    // Pack up to two results with the last mark
    jls_pkg::lex_res_t slot0, slot1;
    logic [1:0] push_n;

    always_comb
    begin
        push_n = 2'(pre_valid) + 2'(main_valid);
        slot0  = pre_valid ? pre_res : main_res;
        slot1  = main_res;
        slot0.last = (push_n == 2'd1);
        slot1.last = 1'b1;
        if (!advance)
        begin
            push_n = 2'd0;
        end
    end

    // Result queue
    assign pop           = res.valid && res.ready;
    assign res.valid     = (count_reg != '0);
    assign res.event_res    = q_mem[rd_ptr_reg].event_res;
    assign res.text_char    = q_mem[rd_ptr_reg].text_char;
    assign res.token_class  = q_mem[rd_ptr_reg].token_class;
    assign res.keyword_code = q_mem[rd_ptr_reg].keyword_code;
    assign res.int_value    = q_mem[rd_ptr_reg].int_value;
    assign res.error        = q_mem[rd_ptr_reg].error;
    assign res.last         = q_mem[rd_ptr_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + Q_AW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + Q_AW'(pop);
            count_reg  <= count_reg + Q_CW'(push_n) - Q_CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= slot0;
        end
        if (push_n == 2'd2)
        begin
            q_mem[wr_ptr_reg + Q_AW'(1)] <= slot1;
        end
    end

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for jack_lexer_stream_top, fed one source byte per request.
// Depends on jls_pkg (modes, classes, error codes, result struct) and jls_if (channels).
module tb_top;
    import jls_pkg::*;

    localparam int WORD_KEEP    = 11;
    localparam int NUM_KW       = 21;
    localparam int RANDOM_ITEMS = 1150;
    localparam int QUIET_TAIL   = 120;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RUN_LIMIT    = 2000000;

    typedef struct {
        logic [7:0] ch;
        logic       eof;
        logic       drain;
    } src_item_t;

    logic clk = 1'b0;
    logic rst_n;

    jls_in_if  src_if ();
    jls_out_if res_if ();

    jack_lexer_stream_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_if),
        .res   (res_if)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("jack_lexer_stream_top test failed");
        $finish;
    end

    string kw_names [NUM_KW] = '{
        "class", "method", "function", "constructor", "int", "boolean", "char",
        "void", "var", "static", "field", "let", "do", "if", "else", "while",
        "return", "true", "false", "null", "this"
    };
    string sym_chars  = "(){}[].,;+-*/&<>=|~";
    string word_chars = "abcdefghijklmnopqrstuvwxyzQXZ_0123456789";
    string gap_chars  = "a */x*";
    logic [7:0] sep_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    src_item_t  source_bytes_q [$];
    lex_res_t   token_events_q [$];
    logic       drain_mark;
    int         total_items;
    int         accepted_count = 0;
    int         fail_count     = 0;
    int         src_gap        = 0;
    int         res_gap        = 0;

    // Lexer state as the bench sees it
    lex_mode_t   lx_mode;
    logic [7:0]  lx_word [WORD_KEEP];
    logic [3:0]  lx_len;
    logic        lx_num;
    logic [14:0] lx_acc;
    logic        lx_sat;
    lex_res_t    step_res [2];
    int          step_n;

    // ---------------------------------------------------------------
    // Character classes
    // ---------------------------------------------------------------
    function automatic logic sep_byte(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic sym_byte(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < sym_chars.len(); i++)
            if (sym_chars[i] == c)
                hit = 1'b1;
        return hit;
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic word_byte(input logic [7:0] c);
        return !sep_byte(c) && !sym_byte(c) && (c != CH_QUOTE);
    endfunction

    // ---------------------------------------------------------------
    // Token prediction
    // ---------------------------------------------------------------
    task automatic put_event(input logic ev, input logic [7:0] tc, input logic [2:0] cls,
                             input logic [4:0] kw, input logic [14:0] iv, input logic [1:0] err);
        if (step_n < 2)
        begin
            step_res[step_n] = '{ev, tc, cls, kw, iv, err, 1'b0};
            step_n++;
        end
    endtask

    task automatic add_char(input logic [7:0] c);
        int v;
        if (lx_len < WORD_KEEP)
            lx_word[lx_len] = c;
        if (lx_len != WORD_LEN_MAX)
            lx_len++;
        if (lx_num)
        begin
            v = int'(lx_acc) * 10 + int'(c) - int'(CH_ZERO);
            if (v > int'(INT_MAX))
            begin
                v = int'(INT_MAX);
                lx_sat = 1'b1;
            end
            lx_acc = v[14:0];
        end
        put_event(EV_CHAR, c, '0, '0, '0, ERR_NONE);
    endtask

    task automatic open_word(input logic [7:0] c);
        lx_len  = '0;
        lx_num  = digit_byte(c);
        lx_acc  = '0;
        lx_sat  = 1'b0;
        lx_mode = MODE_WORD;
        add_char(c);
    endtask

    task automatic close_word();
        int  hit;
        logic same;
        if (lx_num)
            put_event(EV_TOKEN_END, '0, CLS_INTEGER, '0, lx_acc,
                      lx_sat ? ERR_INT_SAT : ERR_NONE);
        else
        begin
            hit = -1;
            for (int k = 0; k < NUM_KW; k++)
            begin
                if (hit < 0 && kw_names[k].len() == int'(lx_len))
                begin
                    same = 1'b1;
                    for (int i = 0; i < kw_names[k].len(); i++)
                        if (lx_word[i] != kw_names[k][i])
                            same = 1'b0;
                    if (same)
                        hit = k;
                end
            end
            if (hit >= 0)
                put_event(EV_TOKEN_END, '0, CLS_KEYWORD, hit[4:0], '0, ERR_NONE);
            else
                put_event(EV_TOKEN_END, '0, CLS_IDENT, '0, '0, ERR_NONE);
        end
        lx_len  = '0;
        lx_num  = 1'b0;
        lx_acc  = '0;
        lx_sat  = 1'b0;
        lx_mode = MODE_NORMAL;
    endtask

    task automatic plain_byte(input logic [7:0] c);
        lx_mode = MODE_NORMAL;
        if (!sep_byte(c))
        begin
            if (c == CH_QUOTE)
                lx_mode = MODE_STRING;
            else if (c == CH_SLASH)
                lx_mode = MODE_SLASH;
            else if (sym_byte(c))
                put_event(EV_TOKEN_END, c, CLS_SYMBOL, '0, '0, ERR_NONE);
            else
                open_word(c);
        end
    endtask

    // One accepted byte: advance the lexer and queue the token events it causes
    task automatic lex_byte(input logic [7:0] c, input logic eof);
        step_n = 0;
        case (lx_mode)
            MODE_WORD:
            begin
                if (eof)
                    close_word();
                else if (word_byte(c))
                begin
                    if (lx_num && !digit_byte(c))
                    begin
                        close_word();
                        open_word(c);
                    end
                    else
                        add_char(c);
                end
                else
                begin
                    close_word();
                    plain_byte(c);
                end
            end
            MODE_STRING:
            begin
                if (eof || c == CH_LF)
                begin
                    put_event(EV_TOKEN_END, '0, CLS_STRING, '0, '0, ERR_UNTERM_STR);
                    lx_mode = MODE_NORMAL;
                end
                else if (c == CH_QUOTE)
                begin
                    put_event(EV_TOKEN_END, '0, CLS_STRING, '0, '0, ERR_NONE);
                    lx_mode = MODE_NORMAL;
                end
                else
                    put_event(EV_CHAR, c, '0, '0, '0, ERR_NONE);
            end
            MODE_SLASH:
            begin
                if (eof)
                begin
                    put_event(EV_TOKEN_END, CH_SLASH, CLS_SYMBOL, '0, '0, ERR_NONE);
                    lx_mode = MODE_NORMAL;
                end
                else if (c == CH_SLASH)
                    lx_mode = MODE_LINE;
                else if (c == CH_STAR)
                    lx_mode = MODE_BLOCK;
                else
                begin
                    put_event(EV_TOKEN_END, CH_SLASH, CLS_SYMBOL, '0, '0, ERR_NONE);
                    plain_byte(c);
                end
            end
            MODE_LINE:
            begin
                if (eof || c == CH_LF)
                    lx_mode = MODE_NORMAL;
            end
            MODE_BLOCK, MODE_STAR:
            begin
                if (eof)
                begin
                    put_event(EV_TOKEN_END, '0, CLS_KEYWORD, '0, '0, ERR_OPEN_COMMENT);
                    lx_mode = MODE_NORMAL;
                end
                else if (c == CH_STAR)
                    lx_mode = MODE_STAR;
                else if (lx_mode == MODE_STAR && c == CH_SLASH)
                    lx_mode = MODE_NORMAL;
                else
                    lx_mode = MODE_BLOCK;
            end
            default:
            begin
                lx_mode = MODE_NORMAL;
                if (!eof)
                    plain_byte(c);
            end
        endcase
        if (step_n > 0)
            step_res[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            token_events_q.push_back(step_res[i]);
    endtask

    // ---------------------------------------------------------------
    // Source text building
    // ---------------------------------------------------------------
    task automatic push_byte(input logic [7:0] c);
        source_bytes_q.push_back('{c, 1'b0, drain_mark});
        drain_mark = 1'b0;
    endtask

    task automatic push_eof();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        source_bytes_q.push_back('{junk, 1'b1, drain_mark});
        drain_mark = 1'b0;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_printable();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        return (c == CH_QUOTE) ? CH_STAR : c;
    endfunction

    // One token, comment or piece of noise, then usually a separator
    task automatic add_random_token();
        int    kind;
        int    n;
        int    pick;
        string kw;
        kind = $urandom_range(0, 99);
        if (kind < 18)
            push_text(kw_names[$urandom_range(0, NUM_KW-1)]);
        else if (kind < 32)
        begin
            // identifier, now and then longer than the kept prefix
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 17) : $urandom_range(1, 8);
            push_byte(word_chars[$urandom_range(0, 29)]);
            for (int i = 1; i < n; i++)
                push_byte(word_chars[$urandom_range(0, word_chars.len()-1)]);
        end
        else if (kind < 44)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                push_text("32767");
            else if (pick == 1)
                push_text("32768");
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(8'h30, 8'h39)));
            end
        end
        else if (kind < 58)
            push_byte(sym_chars[$urandom_range(0, sym_chars.len()-1)]);
        else if (kind < 66)
        begin
            // string; any byte but quote and newline may appear inside
            push_byte(CH_QUOTE);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 3) != 0)
                    push_byte(rand_printable());
                else
                begin
                    pick = $urandom_range(0, 255);
                    if (pick == CH_QUOTE || pick == CH_LF)
                        pick = CH_SLASH;
                    push_byte(8'(pick));
                end
            end
            push_byte(CH_QUOTE);
        end
        else if (kind < 72)
        begin
            push_text("//");
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                push_byte(rand_printable());
            push_byte(CH_LF);
        end
        else if (kind < 78)
        begin
            push_text("/*");
            if ($urandom_range(0, 1) == 0)
                push_byte(CH_STAR);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                push_byte(gap_chars[$urandom_range(0, gap_chars.len()-1)]);
            push_text("*/");
        end
        else if (kind < 86)
            push_byte(8'($urandom_range(0, 255)));
        else if (kind < 90)
            push_eof();
        else
        begin
            // broken sequences
            kw = kw_names[$urandom_range(0, NUM_KW-1)];
            case ($urandom_range(0, 5))
                0: push_text({kw, "x"});
                1: push_text(kw.substr(0, kw.len()-2));
                2: push_text("\"ab\n");
                3:
                begin
                    push_text("/*ab");
                    push_eof();
                end
                4:
                begin
                    push_text("\"a/");
                    push_eof();
                end
                default: push_text("12ab");
            endcase
        end
        if ($urandom_range(0, 4) != 0)
        begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++)
                push_byte(sep_chars[$urandom_range(0, 5)]);
        end
    endtask

    function automatic string fmt_event(input lex_res_t r);
        return $sformatf("ev=%0d ch=%02h cls=%0d kw=%0d int=%0d err=%0d last=%0d",
                         r.event_res, r.text_char, r.token_class, r.keyword_code,
                         r.int_value, r.error, r.last);
    endfunction

    function automatic logic tail_phase();
        return source_bytes_q.size() < QUIET_TAIL;
    endfunction

    // ---------------------------------------------------------------
    // Source driver: predicts on each accepted request, then presents the next byte
    // ---------------------------------------------------------------
    src_item_t next_item;
    logic      drive_valid;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_if.valid <= 1'b0;
        end
        else
        begin
            if (src_if.valid && src_if.ready)
            begin
                lex_byte(src_if.ch, src_if.end_of_file);
                accepted_count++;
            end
            drive_valid = src_if.valid && !src_if.ready;
            if (!drive_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (source_bytes_q.size() != 0 &&
                         !(source_bytes_q[0].drain && token_events_q.size() != 0))
                begin
                    next_item   = source_bytes_q.pop_front();
                    drive_valid = 1'b1;
                    src_if.ch          <= next_item.ch;
                    src_if.end_of_file <= next_item.eof;
                    if (!tail_phase() && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 15);
                end
            end
            src_if.valid <= drive_valid;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: checks each accepted result against the oldest prediction
    // ---------------------------------------------------------------
    lex_res_t seen;
    lex_res_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                seen.event_res    = res_if.event_res;
                seen.text_char    = res_if.text_char;
                seen.token_class  = res_if.token_class;
                seen.keyword_code = res_if.keyword_code;
                seen.int_value    = res_if.int_value;
                seen.error        = res_if.error;
                seen.last         = res_if.last;
                if (token_events_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: %s", fmt_event(seen));
                end
                else
                begin
                    want = token_events_q.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %s, got %s",
                                     fmt_event(want), fmt_event(seen));
                    end
                end
            end
            if (res_gap > 0)
            begin
                res_gap--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (!tail_phase() && $urandom_range(0, 11) == 0)
                    res_gap = $urandom_range(1, 15);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus, reset and end of run
    // ---------------------------------------------------------------
    initial
    begin
        int directed_n;
        int wait_cycles;

        rst_n              = 1'b0;
        src_if.valid       = 1'b0;
        src_if.ch          = '0;
        src_if.end_of_file = 1'b0;
        res_if.ready       = 1'b0;

        lx_mode = MODE_NORMAL;
        lx_len  = '0;
        lx_num  = 1'b0;
        lx_acc  = '0;
        lx_sat  = 1'b0;
        drain_mark = 1'b0;

        // saturating integer then a letter, string holding comment marks cut by newline
        push_text("99999x ");
        push_text("\"/*\n");
        // block comment: slash-star-slash does not close it
        push_text("/*/*/");
        // held slash closed by end of file; string, block and line comment open at end of file
        push_text("a/");
        push_eof();
        push_text("\"x");
        push_eof();
        push_text("/*");
        push_eof();
        push_text("//");
        push_eof();
        // extreme byte values as word characters, word open at end of file
        push_byte(8'h00);
        push_byte(8'hFF);
        push_eof();
        directed_n = source_bytes_q.size();

        // random part; hold off until everything before has drained, here and now and then later
        drain_mark = 1'b1;
        while (source_bytes_q.size() < directed_n + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 299) == 0)
                drain_mark = 1'b1;
            add_random_token();
        end
        total_items = source_bytes_q.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count != total_items)
            @(posedge clk);
        wait_cycles = 0;
        while (token_events_q.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (token_events_q.size() != 0)
        begin
            fail_count += token_events_q.size();
            $display("%0d predicted results never arrived", token_events_q.size());
        end

        if (fail_count == 0)
            $display("jack_lexer_stream_top test passed");
        else
            $display("jack_lexer_stream_top test failed");
        $finish;
    end

endmodule
